// ===== sv/kmsr_pkg.sv =====
// kmsr_pkg: shared types, widths and the keymap rom for the key matrix scanner
// no dependencies; used by every module of the block
package kmsr_pkg;

  localparam int unsigned COL_W  = 4;
  localparam int unsigned ROW_W  = 8;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned KEYS_W = 7;

  localparam int unsigned ROM_COLS = 16;
  localparam int unsigned ROM_ROWS = 8;

  // hid usage codes whose top three bits match this prefix (e0 and above) are modifier keys
  localparam logic [2:0] MOD_PREFIX = 3'b111;

  localparam logic [KEYS_W-1:0] MAX_KEYS_RESET = 7'd7;

  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic [ROW_W-1:0] row_levels;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              is_modifier_byte;
    logic              last_of_scan;
  } out_item_t;

  // what one row lane found
  typedef struct packed {
    logic              pressed;
    logic              is_mod;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] mod_mask;
  } lane_hit_t;

  // results of one item handed to the output queue
  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  localparam logic [CODE_W-1:0] KEYMAP [ROM_COLS][ROM_ROWS] = '{
    '{8'h0B, 8'h23, 8'h1C, 8'h18, 8'h0D, 8'h24, 8'h10, 8'h11},
    '{8'h3F, 8'h2E, 8'h30, 8'h0C, 8'h0E, 8'h25, 8'h36, 8'h00},
    '{8'h3E, 8'h42, 8'h2A, 8'h00, 8'h31, 8'h43, 8'h28, 8'h2C},
    '{8'h00, 8'h41, 8'h40, 8'h12, 8'h0F, 8'h26, 8'h37, 8'h00},
    '{8'h0A, 8'h22, 8'h17, 8'h15, 8'h09, 8'h21, 8'h19, 8'h05},
    '{8'h34, 8'h2D, 8'h2F, 8'h13, 8'h33, 8'h27, 8'h00, 8'h38},
    '{8'h3D, 8'h3B, 8'h3C, 8'h08, 8'h07, 8'h20, 8'h06, 8'h00},
    '{8'h66, 8'h4C, 8'h80, 8'h80, 8'h7F, 8'h44, 8'h00, 8'h51},
    '{8'h00, 8'h3A, 8'h39, 8'h1A, 8'h16, 8'h1F, 8'h1B, 8'h00},
    '{8'h00, 8'h49, 8'h00, 8'h00, 8'h00, 8'h45, 8'h00, 8'h4F},
    '{8'h29, 8'h35, 8'h2B, 8'h14, 8'h04, 8'h1E, 8'h1D, 8'h00},
    '{8'h00, 8'h4B, 8'h00, 8'hE3, 8'h65, 8'h4E, 8'h4B, 8'h4E},
    '{8'h00, 8'h00, 8'hE1, 8'h00, 8'h00, 8'h00, 8'hE5, 8'h00},
    '{8'h52, 8'h4A, 8'h00, 8'h00, 8'h00, 8'h4D, 8'h48, 8'h50},
    '{8'h00, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4, 8'h00},
    '{8'hE2, 8'h00, 8'h00, 8'h47, 8'h00, 8'h46, 8'h00, 8'hE6}
  };

  function automatic logic [CODE_W-1:0] keymap_lookup(logic [COL_W-1:0] col,
                                                      logic [2:0] row);
    return KEYMAP[col][row];
  endfunction

endpackage

// ===== sv/kmsr_lane.sv =====
// kmsr_lane: one row lane, checks its row level and looks up its keymap entry
// depends on kmsr_pkg
module kmsr_lane #(
  parameter int unsigned LANE_IDX = 0
) (
  input  logic [kmsr_pkg::COL_W-1:0] column_index_i,
  input  logic                       level_i,
  output kmsr_pkg::lane_hit_t        hit_o
);

  logic [kmsr_pkg::CODE_W-1:0] code;

  assign code = kmsr_pkg::keymap_lookup(column_index_i, 3'(LANE_IDX));

  always_comb begin
    hit_o.pressed  = ~level_i;
    hit_o.code     = code;
    hit_o.is_mod   = (code[7:5] == kmsr_pkg::MOD_PREFIX);
    // only e0..e7 land inside the modifier byte
    hit_o.mod_mask = '0;
    if (hit_o.is_mod && (code[4:3] == 2'b00)) begin
      hit_o.mod_mask = kmsr_pkg::CODE_W'(1) << code[2:0];
    end
  end

endmodule

// ===== sv/kmsr_merge.sv =====
// kmsr_merge: picks the lowest pressed row lane and keeps the per-scan state
// depends on kmsr_pkg; feeds the output queue with up to two results per item
module kmsr_merge #(
  parameter int unsigned NUM_COLS = 16,
  parameter int unsigned NUM_ROWS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [kmsr_pkg::COL_W-1:0]  column_index_i,
  input  kmsr_pkg::lane_hit_t         hits_i [NUM_ROWS],
  input  logic [kmsr_pkg::KEYS_W-1:0] max_keys_i,
  output kmsr_pkg::push_t             push_o
);

  logic [kmsr_pkg::CODE_W-1:0] mod_accum_q, mod_accum_d;
  logic [kmsr_pkg::KEYS_W-1:0] keys_q, keys_d;
  logic                        stopped_q, stopped_d;

  logic                        start, active, found, last_col;
  logic                        emit_key, cap_hit, mod_out;
  kmsr_pkg::lane_hit_t         sel;
  logic [kmsr_pkg::CODE_W-1:0] acc_base, acc_new;
  logic [kmsr_pkg::KEYS_W-1:0] keys_base, keys_new, cap;
  logic                        stop_base;
  kmsr_pkg::out_item_t         key_item, mod_item;

  // lowest pressed row wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (hits_i[r].pressed) begin
        found = 1'b1;
        sel   = hits_i[r];
      end
    end
  end

  always_comb begin
    start     = (column_index_i == '0);
    acc_base  = start ? '0 : mod_accum_q;
    keys_base = start ? '0 : keys_q;
    stop_base = start ? 1'b0 : stopped_q;
    active    = !stop_base && ({1'b0, column_index_i} < (kmsr_pkg::COL_W + 1)'(NUM_COLS));
    last_col  = (column_index_i == kmsr_pkg::COL_W'(NUM_COLS - 1));
    // a zero capacity behaves as one
    cap       = (max_keys_i == '0) ? '0 : max_keys_i - 1'b1;

    acc_new   = acc_base | ((found && sel.is_mod) ? sel.mod_mask : '0);
    emit_key  = found && !sel.is_mod && (keys_base < cap);
    keys_new  = keys_base + kmsr_pkg::KEYS_W'(emit_key);
    cap_hit   = found && (keys_new >= cap);
    mod_out   = active && (cap_hit || last_col);

    key_item.code             = sel.code;
    key_item.is_modifier_byte = 1'b0;
    key_item.last_of_scan     = 1'b0;
    mod_item.code             = acc_new;
    mod_item.is_modifier_byte = 1'b1;
    mod_item.last_of_scan     = 1'b1;

    push_o = '0;
    if (accept_i && active) begin
      if (emit_key) begin
        push_o.first  = key_item;
        push_o.second = mod_item;
        push_o.num    = mod_out ? 2'd2 : 2'd1;
      end else if (mod_out) begin
        push_o.first = mod_item;
        push_o.num   = 2'd1;
      end
    end

    mod_accum_d = mod_accum_q;
    keys_d      = keys_q;
    stopped_d   = stopped_q;
    if (accept_i) begin
      mod_accum_d = active ? acc_new : acc_base;
      keys_d      = active ? keys_new : keys_base;
      stopped_d   = active ? mod_out : stop_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_accum_q <= '0;
      keys_q      <= '0;
      stopped_q   <= 1'b0;
    end else begin
      mod_accum_q <= mod_accum_d;
      keys_q      <= keys_d;
      stopped_q   <= stopped_d;
    end
  end

endmodule

// ===== sv/kmsr_out_queue.sv =====
// kmsr_out_queue: four-entry result queue, takes up to two results a cycle
// depends on kmsr_pkg; drives the output channel of the top level
module kmsr_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kmsr_pkg::push_t     push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kmsr_pkg::out_item_t out_item_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  kmsr_pkg::out_item_t mem_q [DEPTH];

  logic [PTR_W-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // leave space for the worst case of two results per item
  assign room_o      = (cnt_q <= (PTR_W + 1)'(DEPTH - 2));

  always_comb begin
    rd_d  = rd_q + PTR_W'(pop);
    wr_d  = wr_q + PTR_W'(push_i.num);
    cnt_d = cnt_q + (PTR_W + 1)'(push_i.num) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/key_matrix_scan_report_top.sv =====
// Key matrix scanner: takes one scanned column per item and returns boot-report
// results (keycodes, then the modifier byte flagged last). When an item is taken,
// its results (none, one or two) enter a four-entry output queue
// in that same cycle, so columns stream at one per cycle as long as the queue has
// room for two results; the output side drains one result per cycle while not
// stalled, which sets the sustained rate when most columns give results. Row lanes
// look up the keymap in parallel and a merge stage picks the lowest pressed row.
// depends on kmsr_pkg, kmsr_lane, kmsr_merge, kmsr_out_queue
module key_matrix_scan_report_top #(
  parameter int unsigned NUM_COLS = 16,
  parameter int unsigned NUM_ROWS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kmsr_pkg::KEYS_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kmsr_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kmsr_pkg::out_item_t         out_item_o
);

  logic [kmsr_pkg::KEYS_W-1:0] max_keys_q;
  logic                        room, accept;
  kmsr_pkg::lane_hit_t         hits [NUM_ROWS];
  kmsr_pkg::push_t             push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_keys_q <= kmsr_pkg::MAX_KEYS_RESET;
    end else if (cfg_we_i) begin
      max_keys_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    kmsr_lane #(.LANE_IDX(r)) u_lane (
      .column_index_i (in_item_i.column_index),
      .level_i        (in_item_i.row_levels[r]),
      .hit_o          (hits[r])
    );
  end

  kmsr_merge #(.NUM_COLS(NUM_COLS), .NUM_ROWS(NUM_ROWS)) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .column_index_i (in_item_i.column_index),
    .hits_i         (hits),
    .max_keys_i     (max_keys_q),
    .push_o         (push)
  );

  kmsr_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/kmsr_checker.sv =====
// kmsr_checker: port-level checks on the key matrix scanner, bound to the top
// depends on kmsr_pkg and key_matrix_scan_report_top
module kmsr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input kmsr_pkg::out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // the modifier byte always closes a scan, keycodes never do
  a_mod_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.is_modifier_byte == out_item_o.last_of_scan))
    else $error("modifier flag and last flag disagree");

  // an empty queue never stalls the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // results only appear after an accepted item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("output item without an accepted input item");

endmodule

bind key_matrix_scan_report_top kmsr_checker u_kmsr_checker (.*);
